// ===== rtl/swmmm_pkg.sv =====
package swmmm_pkg;

  // Store depth and field widths.
  localparam int MaxWindow = 32;
  localparam int SampleW   = 16;
  localparam int LenW      = 6;
  localparam int IdxW      = $clog2(MaxWindow);
  // A sum of up to MaxWindow samples needs IdxW extra bits.
  localparam int SumW      = SampleW + IdxW;
  localparam int RemW      = LenW + 1;

  localparam logic [LenW-1:0] LenReset = LenW'(MaxWindow);
  localparam logic [LenW-1:0] LenMax   = LenW'(MaxWindow);

  typedef logic signed [SampleW-1:0] sample_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StPrep,
    StDiv,
    StDone
  } state_e;

endpackage

// ===== rtl/sliding_window_mean_min_max.sv =====
// Sliding window statistics over a ring of up to 32 signed 16-bit samples. Each accepted
// item overwrites the oldest entry of the first window_length entries and yields one result
// with the mean (truncated toward zero), minimum and maximum of those entries. The store
// reads as zero after reset, so early results include zeros. A window_length of 0 acts as 1
// and values above 32 act as 32; write it only while the block is idle. An item passes, in
// order, through a scan of the entries of the window in the sample memory, a drain of the
// read pipeline, the setup of the division, a 21-step restoring divider that produces one
// quotient bit per cycle, and the load of the output register. The input is not ready
// while an item is processed, so a new item is accepted only once the previous result has
// been loaded into the output register. The result sits in an output register, so the
// next item is accepted while it waits to be taken; the following result is held back
// until the previous one has been taken.
module sliding_window_mean_min_max (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [swmmm_pkg::LenW-1:0]            cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [swmmm_pkg::SampleW-1:0]  sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [swmmm_pkg::SampleW-1:0]  mean_value_o,
  output logic signed [swmmm_pkg::SampleW-1:0]  minimum_value_o,
  output logic signed [swmmm_pkg::SampleW-1:0]  maximum_value_o
);
  import swmmm_pkg::*;

  state_e state_q, state_d;

  logic [LenW-1:0] cfg_len_q;
  logic [LenW-1:0] eff_len;
  logic [LenW-1:0] len_q;
  logic [IdxW-1:0] wpos_q;
  logic [IdxW-1:0] wpos_cur;
  logic [LenW-1:0] wpos_inc;
  logic [IdxW-1:0] cnt_q;

  sample_t             mem_q [MaxWindow];
  logic [MaxWindow-1:0] vld_q;
  sample_t             rd_data_q;
  logic                rd_vld_q;
  logic                rd_pend_q;
  sample_t             rd_value;

  logic signed [SumW-1:0] sum_q;
  sample_t                lo_q, hi_q;
  logic [SumW-1:0]        quo_q;
  logic [RemW-1:0]        rem_q;
  logic [RemW-1:0]        trial;
  logic                   trial_ge;
  logic                   neg_q;

  logic    out_valid_q;
  sample_t mean_q, min_q, max_q;

  logic in_acc;
  logic scan_last;
  logic div_last;
  logic out_free;
  logic rd_en;
  logic load_out;

  // Configuration register and its effective value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= LenReset;
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    eff_len = cfg_len_q;
    if (cfg_len_q == '0) begin
      eff_len = LenW'(1);
    end else if (cfg_len_q > LenMax) begin
      eff_len = LenMax;
    end
  end

  // Write position: pulled back to zero if the window shrank below it.
  assign wpos_cur = ({1'b0, wpos_q} >= eff_len) ? '0 : wpos_q;
  assign wpos_inc = {1'b0, wpos_cur} + LenW'(1);

  assign in_acc    = in_valid_i && in_ready_o;
  assign scan_last = ({1'b0, cnt_q} == (len_q - LenW'(1)));
  assign div_last  = (cnt_q == IdxW'(SumW - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StScan;
      end
      StScan: begin
        if (scan_last) state_d = StDrain;
      end
      StDrain: begin
        state_d = StPrep;
      end
      StPrep: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_last) state_d = StDone;
      end
      StDone: begin
        if (out_free) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      StIdle:  in_ready_o = 1'b1;
      StScan:  rd_en      = 1'b1;
      StDone:  load_out   = out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Sample memory, written on acceptance and read once per scan cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem_q[wpos_cur] <= sample_i;
    end
    rd_data_q <= mem_q[cnt_q];
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_pend_q <= 1'b0;
      wpos_q    <= '0;
    end else begin
      if (in_acc) begin
        vld_q[wpos_cur] <= 1'b1;
        wpos_q <= (wpos_inc >= eff_len) ? '0 : wpos_inc[IdxW-1:0];
      end
      rd_vld_q  <= vld_q[cnt_q];
      rd_pend_q <= rd_en;
    end
  end

  assign rd_value = rd_vld_q ? rd_data_q : '0;

  // Divider step: one quotient bit per cycle.
  assign trial    = {rem_q[RemW-2:0], quo_q[SumW-1]};
  assign trial_ge = (trial >= {1'b0, len_q});

  // Accumulation, min/max tracking and division.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      len_q <= eff_len;
      cnt_q <= '0;
      sum_q <= '0;
      lo_q  <= {1'b0, {(SampleW-1){1'b1}}};
      hi_q  <= {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      if (rd_en && !scan_last) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
      if (rd_pend_q) begin
        sum_q <= sum_q + SumW'(rd_value);
        if (rd_value < lo_q) lo_q <= rd_value;
        if (rd_value > hi_q) hi_q <= rd_value;
      end
      if (state_q == StPrep) begin
        neg_q <= sum_q[SumW-1];
        quo_q <= sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
        rem_q <= '0;
        cnt_q <= '0;
      end
      if (state_q == StDiv) begin
        rem_q <= trial_ge ? (trial - {1'b0, len_q}) : trial;
        quo_q <= {quo_q[SumW-2:0], trial_ge};
        if (!div_last) cnt_q <= cnt_q + IdxW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      mean_q <= neg_q ? -quo_q[SampleW-1:0] : quo_q[SampleW-1:0];
      min_q  <= lo_q;
      max_q  <= hi_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mean_value_o    = mean_q;
  assign minimum_value_o = min_q;
  assign maximum_value_o = max_q;

endmodule
